[src/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/lpfp_pkg.sv]
package lpfp_pkg;

  localparam int LEN_DIGITS = 3;
  localparam int CNT_W      = $clog2(LEN_DIGITS + 1);

  localparam logic [9:0] MAX_LEN  = 10'd999;
  localparam logic [7:0] NUL_BYTE = 8'h00;
  localparam logic [7:0] ASCII_0  = 8'h30;
  localparam logic [7:0] ASCII_9  = 8'h39;

  typedef enum logic [2:0] {
    PH_LEN   = 3'd0,
    PH_ID    = 3'd1,
    PH_SUB   = 3'd2,
    PH_CONF  = 3'd3,
    PH_MSG   = 3'd4,
    PH_CHECK = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_MSG  = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    FAIL_ID    = 3'd0,
    FAIL_SUBID = 3'd1,
    FAIL_CONF  = 3'd2,
    FAIL_MSG   = 3'd3,
    FAIL_CHECK = 3'd4
  } fail_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [9:0]  byte_index;
    logic [7:0]  dev_id;
    logic [7:0]  sub_dev_id;
    logic [7:0]  conf_byte;
    logic [7:0]  check_byte;
    logic [9:0]  frame_len;
    fail_t       fail_stage;
  } result_t;

  // Handshake between the input register and the parser core.
  typedef struct packed {
    logic       advance;
    logic [7:0] rx_byte;
  } core_in_t;

endpackage

[src/lpfp_in_stage.sv]
module lpfp_in_stage import lpfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       out_free,
  output core_in_t   core_in
);

  logic       full;
  logic [7:0] byte_q;
  logic       advance;

  assign advance  = full && out_free;
  assign in_ready = !full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && in_ready) begin
      full <= 1'b1;
    end else if (advance) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= in_byte;
    end
  end

  assign core_in = '{advance: advance, rx_byte: byte_q};

endmodule

[src/lpfp_core.sv]
module lpfp_core import lpfp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  core_in_t core_in,
  output logic     res_valid,
  output result_t  res
);

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] digit_count, digit_count_next;
  logic             digits_stopped, digits_stopped_next;
  logic [9:0]       length_accum, length_accum_next;
  logic [9:0]       bytes_seen, bytes_seen_next;
  logic [7:0]       held_id, held_id_next;
  logic [7:0]       held_sub_id, held_sub_id_next;
  logic [7:0]       held_conf, held_conf_next;

  logic [7:0]       b;
  logic [CNT_W-1:0] cnt_inc;
  logic [13:0]      acc_mul;
  logic [9:0]       bs_inc;
  logic             err;
  fail_t            err_stage;

  assign b       = core_in.rx_byte;
  assign cnt_inc = digit_count + CNT_W'(1);
  assign acc_mul = {4'd0, length_accum} * 14'd10 + {6'd0, b - ASCII_0};
  assign bs_inc  = bytes_seen + 10'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEN;
      digit_count    <= '0;
      digits_stopped <= 1'b0;
      length_accum   <= '0;
      bytes_seen     <= '0;
      held_id        <= '0;
      held_sub_id    <= '0;
      held_conf      <= '0;
    end else if (core_in.advance) begin
      phase          <= phase_next;
      digit_count    <= digit_count_next;
      digits_stopped <= digits_stopped_next;
      length_accum   <= length_accum_next;
      bytes_seen     <= bytes_seen_next;
      held_id        <= held_id_next;
      held_sub_id    <= held_sub_id_next;
      held_conf      <= held_conf_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    digit_count_next    = digit_count;
    digits_stopped_next = digits_stopped;
    length_accum_next   = length_accum;
    bytes_seen_next     = bytes_seen;
    held_id_next        = held_id;
    held_sub_id_next    = held_sub_id;
    held_conf_next      = held_conf;
    err                 = 1'b0;
    err_stage           = FAIL_ID;
    res_valid           = 1'b0;
    res                 = '0;

    case (phase)
      PH_LEN: begin
        if (!digits_stopped && b >= ASCII_0 && b <= ASCII_9) begin
          length_accum_next = (acc_mul > {4'd0, MAX_LEN}) ? MAX_LEN : acc_mul[9:0];
        end else begin
          digits_stopped_next = 1'b1;
        end
        digit_count_next = cnt_inc;
        if (cnt_inc >= CNT_W'(LEN_DIGITS)) begin
          digit_count_next    = '0;
          digits_stopped_next = 1'b0;
          bytes_seen_next     = '0;
          if (length_accum_next == 10'd0) begin
            err       = 1'b1;
            err_stage = FAIL_ID;
          end else begin
            phase_next = PH_ID;
          end
        end
      end
      PH_ID: begin
        if (b == NUL_BYTE) begin
          err       = 1'b1;
          err_stage = FAIL_ID;
        end else begin
          held_id_next = b;
          if (length_accum <= 10'd1) begin
            err       = 1'b1;
            err_stage = FAIL_SUBID;
          end else begin
            phase_next = PH_SUB;
          end
        end
      end
      PH_SUB: begin
        if (b == NUL_BYTE) begin
          err       = 1'b1;
          err_stage = FAIL_SUBID;
        end else begin
          held_sub_id_next = b;
          if (length_accum <= 10'd2) begin
            err       = 1'b1;
            err_stage = FAIL_CONF;
          end else begin
            phase_next = PH_CONF;
          end
        end
      end
      PH_CONF: begin
        if (b == NUL_BYTE) begin
          err       = 1'b1;
          err_stage = FAIL_CONF;
        end else begin
          held_conf_next = b;
          // length 3 leaves no room for the check byte
          if (length_accum <= 10'd3) begin
            err       = 1'b1;
            err_stage = FAIL_CHECK;
          end else begin
            bytes_seen_next = '0;
            phase_next      = (length_accum == 10'd4) ? PH_CHECK : PH_MSG;
          end
        end
      end
      PH_MSG: begin
        if (b == NUL_BYTE) begin
          err       = 1'b1;
          err_stage = FAIL_MSG;
        end else begin
          res_valid       = 1'b1;
          res.kind        = KIND_MSG;
          res.data_byte   = b;
          res.byte_index  = bytes_seen;
          res.frame_len   = length_accum;
          bytes_seen_next = bs_inc;
          if ({1'b0, bs_inc} + 11'd4 >= {1'b0, length_accum}) begin
            phase_next = PH_CHECK;
          end
        end
      end
      PH_CHECK: begin
        if (b == NUL_BYTE) begin
          err       = 1'b1;
          err_stage = FAIL_CHECK;
        end else begin
          res_valid         = 1'b1;
          res.kind          = KIND_DONE;
          res.dev_id        = held_id;
          res.sub_dev_id    = held_sub_id;
          res.conf_byte     = held_conf;
          res.check_byte    = b;
          res.frame_len     = length_accum;
          phase_next        = PH_LEN;
          digit_count_next  = '0;
          digits_stopped_next = 1'b0;
          length_accum_next = '0;
          bytes_seen_next   = '0;
        end
      end
      default: begin
        phase_next          = PH_LEN;
        digit_count_next    = '0;
        digits_stopped_next = 1'b0;
        length_accum_next   = '0;
        bytes_seen_next     = '0;
      end
    endcase

    // error report carries the length as it stood when the item arrived, or, in the length phase, including that item
    if (err) begin
      res_valid           = 1'b1;
      res                 = '0;
      res.kind            = KIND_ERR;
      res.frame_len       = (phase == PH_LEN) ? length_accum_next : length_accum;
      res.fail_stage      = err_stage;
      phase_next          = PH_LEN;
      digit_count_next    = '0;
      digits_stopped_next = 1'b0;
      length_accum_next   = '0;
      bytes_seen_next     = '0;
    end

    if (!core_in.advance) begin
      res_valid = 1'b0;
    end
  end

endmodule

[src/lpfp_out_stage.sv]
module lpfp_out_stage import lpfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    res_valid,
  input  result_t res,
  output logic    out_free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_q;
  result_t res_q;

  assign out_free  = !valid_q || out_ready;
  assign out_valid = valid_q;
  assign out_res   = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (out_free) begin
      valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      res_q <= res;
    end
  end

endmodule

[src/length_prefixed_frame_parser.sv]
// Length-prefixed frame parser.
// Input stream: one received byte per item on s_axis (tdata[7:0]). A frame is
// three ASCII length digits, ID, sub-ID, configuration byte, the message bytes
// and a trailing check byte that is passed through, only tested against NUL.
// Output stream: at most one item per input byte on m_axis. tuser gives the
// kind: message byte with its index, frame complete with header fields and
// check byte, or frame error with the field that failed.
// Throughput: one byte per clock while m_axis does not stall. Bytes land in an
// input register, the parser state is updated from it, and results go to an
// output register that drives m_axis, so each result passes both registers.
// When m_axis stalls, the output register holds its item; one more byte may be
// taken into the input register, then s_axis_tready drops until the result
// is taken. Bytes that produce no result still need a free output slot.
// Reset (synchronous, rst high) empties both registers and returns the parser
// to waiting for length digits.
module length_prefixed_frame_parser import lpfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] data_byte, [17:8] byte_index, [25:18] dev_id, [33:26] sub_dev_id,
  // [41:34] conf_byte, [49:42] check_byte, [59:50] frame_len,
  // [62:60] fail_stage, [63] zero
  output logic [63:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser    // [1:0] kind
);

  core_in_t core_in;
  logic     out_free;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  lpfp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .out_free (out_free),
    .core_in  (core_in)
  );

  lpfp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .core_in   (core_in),
    .res_valid (res_valid),
    .res       (res)
  );

  lpfp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {1'b0, out_res.fail_stage, out_res.frame_len, out_res.check_byte,
                         out_res.conf_byte, out_res.sub_dev_id, out_res.dev_id,
                         out_res.byte_index, out_res.data_byte};
  assign m_axis_tuser = out_res.kind;

endmodule

[src/lpfp_checker.sv]
`include "assert_macros.svh"

module lpfp_checker import lpfp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic        stalled;
  logic [65:0] out_item;
  logic        msg_item;
  logic        err_item;
  logic        msg_clean;
  logic        err_clean;
  logic        fields_ok;

  assign stalled   = m_axis_tvalid && !m_axis_tready;
  assign out_item  = {m_axis_tuser, m_axis_tdata};
  assign msg_item  = m_axis_tvalid && (m_axis_tuser == KIND_MSG);
  assign err_item  = m_axis_tvalid && (m_axis_tuser == KIND_ERR);
  // message items carry no header, check byte, fail stage or pad
  assign msg_clean = (m_axis_tdata[49:18] == 32'd0) && (m_axis_tdata[63:60] == 4'd0);
  assign err_clean = (m_axis_tdata[49:0] == 50'd0) && (m_axis_tdata[62:60] <= FAIL_CHECK);
  assign fields_ok = (m_axis_tuser <= KIND_ERR) && (m_axis_tdata[59:50] <= MAX_LEN);

  `ASSERT_CLK(a_out_hold, clk, rst, stalled |=> m_axis_tvalid && $stable(out_item), "item changed in stall")

  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_axis_tvalid, "output valid after reset")

  `ASSERT_CLK(a_msg_fields, clk, rst, msg_item |-> msg_clean, "message item carries header fields")

  `ASSERT_CLK(a_err_fields, clk, rst, err_item |-> err_clean, "error item malformed")

  `ASSERT_CLK(a_kind_code, clk, rst, m_axis_tvalid |-> fields_ok, "bad kind or length")

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (.*);
